FILE: sv/rdmc_pkg.sv
// ----------------------------------------------------------------------------
// rdmc_pkg: shared types and constants
// Command, drive and register codes, configuration and result structs, and
// the hold-timer helper used by the robot drive mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package rdmc_pkg;

	// width of the avoidance hold timer
	localparam int TIMER_BITS = 16;
	localparam int HOLD_W     = 16;
	localparam int CMP_W      = (TIMER_BITS > HOLD_W) ? TIMER_BITS : HOLD_W;

	// item kinds
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_BYTE = 2'd1;
	localparam logic [1:0] CMD_STEP = 2'd2;

	// link bytes with a meaning of their own
	localparam logic [7:0] BYTE_TOGGLE = 8'hFE;
	localparam logic [7:0] BYTE_START  = 8'hFF;

	// drive commands
	localparam logic [3:0] DRV_STOP     = 4'd0;
	localparam logic [3:0] DRV_FWD      = 4'd1;
	localparam logic [3:0] DRV_BACK     = 4'd2;
	localparam logic [3:0] DRV_CURVE_L  = 4'd3;
	localparam logic [3:0] DRV_CURVE_R  = 4'd4;
	localparam logic [3:0] DRV_BCURVE_L = 4'd5;
	localparam logic [3:0] DRV_BCURVE_R = 4'd6;
	localparam logic [3:0] DRV_TURN_L   = 4'd7;
	localparam logic [3:0] DRV_TURN_R   = 4'd8;

	// avoidance machine states
	localparam logic [1:0] AV_FWD     = 2'd0;
	localparam logic [1:0] AV_REVERSE = 2'd1;
	localparam logic [1:0] AV_TURN    = 2'd2;
	localparam logic [1:0] AV_PAUSE   = 2'd3;

	// register indexes
	localparam logic [2:0] REG_OBSTACLE = 3'd0;
	localparam logic [2:0] REG_DEADZONE = 3'd1;
	localparam logic [2:0] REG_TIMEOUT  = 3'd2;
	localparam logic [2:0] REG_REVERSE  = 3'd3;
	localparam logic [2:0] REG_BACKUP   = 3'd4;
	localparam logic [2:0] REG_TURN     = 3'd5;
	localparam logic [2:0] REG_RETRY    = 3'd6;
	localparam logic [2:0] REG_RESUME   = 3'd7;

	typedef struct packed {
		logic [9:0]        obstacle_distance;
		logic [14:0]       dead_zone;
		logic [9:0]        link_timeout_ms;
		logic [HOLD_W-1:0] reverse_hold_ms;
		logic [HOLD_W-1:0] backup_hold_ms;
		logic [HOLD_W-1:0] turn_hold_ms;
		logic [HOLD_W-1:0] retry_hold_ms;
		logic [HOLD_W-1:0] resume_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic       drive_valid;
		logic [3:0] drive_command;
		logic       manual_mode;
	} res_t;

	// saturate a hold value into the timer
	function automatic logic [TIMER_BITS-1:0] sat_hold(input logic [HOLD_W-1:0] v);
		logic [CMP_W-1:0] v_ext;
		logic [CMP_W-1:0] max_ext;
		v_ext   = CMP_W'(v);
		max_ext = CMP_W'({TIMER_BITS{1'b1}});
		if (v_ext > max_ext) begin
			return {TIMER_BITS{1'b1}};
		end
		return TIMER_BITS'(v_ext);
	endfunction

endpackage

`default_nettype wire

FILE: sv/rdmc_cfg.sv
// ----------------------------------------------------------------------------
// rdmc_cfg: configuration register bank
// Holds the eight settings and updates one on each write.
// ----------------------------------------------------------------------------
`default_nettype none

module rdmc_cfg (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire  [2:0]        cfg_index,
	input  wire  [15:0]       cfg_data,
	output rdmc_pkg::cfg_t    cfg
);
	import rdmc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.obstacle_distance <= 10'd20;
			cfg_q.dead_zone         <= 15'd100;
			cfg_q.link_timeout_ms   <= 10'd50;
			cfg_q.reverse_hold_ms   <= HOLD_W'(800);
			cfg_q.backup_hold_ms    <= HOLD_W'(500);
			cfg_q.turn_hold_ms      <= HOLD_W'(1500);
			cfg_q.retry_hold_ms     <= HOLD_W'(300);
			cfg_q.resume_hold_ms    <= HOLD_W'(500);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_OBSTACLE: cfg_q.obstacle_distance <= cfg_data[9:0];
				REG_DEADZONE: cfg_q.dead_zone         <= cfg_data[14:0];
				REG_TIMEOUT:  cfg_q.link_timeout_ms   <= cfg_data[9:0];
				REG_REVERSE:  cfg_q.reverse_hold_ms   <= cfg_data;
				REG_BACKUP:   cfg_q.backup_hold_ms    <= cfg_data;
				REG_TURN:     cfg_q.turn_hold_ms      <= cfg_data;
				REG_RETRY:    cfg_q.retry_hold_ms     <= cfg_data;
				REG_RESUME:   cfg_q.resume_hold_ms    <= cfg_data;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/rdmc_core.sv
// ----------------------------------------------------------------------------
// rdmc_core: input register and control state
// Registers each item, then in one pass updates the mode, link frame and
// avoidance machine and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rdmc_core (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [1:0]        command,
	input  wire  [7:0]        link_byte,
	input  wire  [9:0]        distance_cm,
	input  rdmc_pkg::cfg_t    cfg,
	input  wire               buf_full,
	output logic              res_push,
	output rdmc_pkg::res_t    res
);
	import rdmc_pkg::*;

	// input stage
	logic        v_s1;
	logic [1:0]  cmd_s1;
	logic [7:0]  byte_s1;
	logic [9:0]  dist_s1;

	// control state
	logic                  mode_q;
	logic [1:0]            avoid_q;
	logic [TIMER_BITS-1:0] timer_q;
	logic                  turn_r_q;
	logic [2:0]            phase_q;
	logic [23:0]           frame_q;
	logic [9:0]            silence_q;

	logic                  mode_d;
	logic [1:0]            avoid_d;
	logic [TIMER_BITS-1:0] timer_d;
	logic                  turn_r_d;
	logic [2:0]            phase_d;
	logic [23:0]           frame_d;
	logic [9:0]            silence_d;
	logic                  drv_valid;
	logic [3:0]            drv_cmd;

	logic [9:0]            lim;
	logic [9:0]            sil_inc;
	logic                  obstacle;
	logic signed [16:0]    x_w;
	logic signed [16:0]    y_w;
	logic signed [16:0]    dz_pos;
	logic signed [16:0]    dz_neg;
	logic                  x_hi, x_lo, y_hi, y_lo;
	logic [3:0]            decoded;

	assign res_push = v_s1 && !buf_full;
	assign in_ready = !v_s1 || !buf_full;

	// hold the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= command;
			byte_s1 <= link_byte;
			dist_s1 <= distance_cm;
		end
	end

	// joystick frame decode
	assign x_w    = 17'(signed'(frame_q[23:8]));
	assign y_w    = 17'(signed'({frame_q[7:0], byte_s1}));
	assign dz_pos = signed'({2'b00, cfg.dead_zone});
	assign dz_neg = -dz_pos;
	assign x_hi   = x_w > dz_pos;
	assign x_lo   = x_w < dz_neg;
	assign y_hi   = y_w > dz_pos;
	assign y_lo   = y_w < dz_neg;

	always_comb begin
		priority if (y_hi) begin
			decoded = x_hi ? DRV_CURVE_R : (x_lo ? DRV_CURVE_L : DRV_FWD);
		end else if (y_lo) begin
			decoded = x_hi ? DRV_BCURVE_R : (x_lo ? DRV_BCURVE_L : DRV_BACK);
		end else begin
			decoded = x_hi ? DRV_TURN_R : (x_lo ? DRV_TURN_L : DRV_STOP);
		end
	end

	assign lim      = (cfg.link_timeout_ms != 10'd0) ? cfg.link_timeout_ms : 10'd1;
	assign sil_inc  = (silence_q != 10'h3FF) ? silence_q + 10'd1 : silence_q;
	assign obstacle = (dist_s1 != 10'd0) && (dist_s1 < cfg.obstacle_distance);

	// next state and result
	always_comb begin
		mode_d    = mode_q;
		avoid_d   = avoid_q;
		timer_d   = timer_q;
		turn_r_d  = turn_r_q;
		phase_d   = phase_q;
		frame_d   = frame_q;
		silence_d = silence_q;
		drv_valid = 1'b0;
		drv_cmd   = DRV_STOP;
		unique case (cmd_s1)
			CMD_TICK: begin
				if (timer_q != '0) begin
					timer_d = timer_q - 1'b1;
				end
				if (mode_q) begin
					silence_d = sil_inc;
					if (sil_inc >= lim) begin
						drv_valid = 1'b1;
						silence_d = 10'd0;
						phase_d   = 3'd0;
					end
				end
			end
			CMD_BYTE: begin
				if (!mode_q) begin
					if (byte_s1 == BYTE_TOGGLE) begin
						mode_d    = 1'b1;
						phase_d   = 3'd0;
						silence_d = 10'd0;
					end
				end else begin
					silence_d = 10'd0;
					if (phase_q == 3'd0) begin
						if (byte_s1 == BYTE_TOGGLE) begin
							mode_d    = 1'b0;
							avoid_d   = AV_FWD;
							drv_valid = 1'b1;
						end else if (byte_s1 == BYTE_START) begin
							phase_d = 3'd1;
						end
					end else if (phase_q < 3'd4) begin
						frame_d = {frame_q[15:0], byte_s1};
						phase_d = phase_q + 3'd1;
					end else begin
						drv_valid = 1'b1;
						drv_cmd   = decoded;
						phase_d   = 3'd0;
					end
				end
			end
			CMD_STEP: begin
				if (!mode_q && timer_q == '0) begin
					drv_valid = 1'b1;
					unique case (avoid_q)
						AV_FWD: begin
							if (obstacle) begin
								avoid_d = AV_REVERSE;
								timer_d = sat_hold(cfg.reverse_hold_ms);
							end else begin
								drv_cmd = DRV_FWD;
							end
						end
						AV_REVERSE: begin
							drv_cmd = DRV_BACK;
							avoid_d = AV_TURN;
							timer_d = sat_hold(cfg.backup_hold_ms);
						end
						AV_TURN: begin
							drv_cmd = turn_r_q ? DRV_CURVE_R : DRV_CURVE_L;
							avoid_d = AV_PAUSE;
							timer_d = sat_hold(cfg.turn_hold_ms);
						end
						AV_PAUSE: begin
							if (obstacle) begin
								avoid_d = AV_REVERSE;
								timer_d = sat_hold(cfg.retry_hold_ms);
							end else begin
								turn_r_d = !turn_r_q;
								avoid_d  = AV_FWD;
								timer_d  = sat_hold(cfg.resume_hold_ms);
							end
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// advance the state when the result is pushed into the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			avoid_q   <= AV_FWD;
			timer_q   <= '0;
			turn_r_q  <= 1'b0;
			phase_q   <= 3'd0;
			silence_q <= 10'd0;
		end else if (res_push) begin
			mode_q    <= mode_d;
			avoid_q   <= avoid_d;
			timer_q   <= timer_d;
			turn_r_q  <= turn_r_d;
			phase_q   <= phase_d;
			silence_q <= silence_d;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			frame_q <= frame_d;
		end
	end

	// result fields: drive_valid, drive_command, manual_mode
	assign res = {drv_valid, drv_cmd, mode_d};

endmodule

`default_nettype wire

FILE: sv/rdmc_outbuf.sv
// ----------------------------------------------------------------------------
// rdmc_outbuf: two-entry result buffer
// Holds results until the receiver takes them, so the input side keeps
// moving while one result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module rdmc_outbuf (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  rdmc_pkg::res_t    res,
	output logic              full,
	output logic              out_valid,
	input  wire               out_ready,
	output logic              drive_valid,
	output logic [3:0]        drive_command,
	output logic              manual_mode
);
	import rdmc_pkg::*;

	res_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;
	res_t       head;

	assign full      = count_q == 2'd2;
	assign out_valid = count_q != 2'd0;
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_ptr_q];

	assign drive_valid   = head.drive_valid;
	assign drive_command = head.drive_command;
	assign manual_mode   = head.manual_mode;

	// store a new result
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

FILE: sv/robot_drive_mode_controller.sv
// ----------------------------------------------------------------------------
// robot_drive_mode_controller: drive mode controller top level
// Turns millisecond ticks, link bytes and control steps into drive commands.
//
// Input channel (in_valid/in_ready): one item is a tick, a link byte or a
// control step with a range reading. Every item gives exactly one result on
// the output channel (out_valid/out_ready) carrying drive_valid,
// drive_command and the mode after the item.
// An accepted item waits in the input register; its result is written to the
// result buffer once that has room and is offered to the receiver from there.
// Throughput: one item per cycle unless both buffer entries are full; the
// state update is a single pass of logic from input register to buffer.
// The two-entry result buffer keeps in_ready high while one result waits;
// when both entries are full the input register holds and in_ready drops
// until the receiver takes a result.
// Configuration (cfg_valid/cfg_ready): always ready, one register per write.
// Write it only while no item is in flight.
// Reset: autonomous mode, avoidance machine at forward, timers and counters
// cleared, settings back to their defaults, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module robot_drive_mode_controller (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  command,
	input  wire  [7:0]  link_byte,
	input  wire  [9:0]  distance_cm,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        drive_valid,
	output logic [3:0]  drive_command,
	output logic        manual_mode,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data
);
	import rdmc_pkg::*;

	cfg_t cfg;
	res_t res;
	logic res_push;
	logic buf_full;

	rdmc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rdmc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.link_byte   (link_byte),
		.distance_cm (distance_cm),
		.cfg         (cfg),
		.buf_full    (buf_full),
		.res_push    (res_push),
		.res         (res)
	);

	rdmc_outbuf u_outbuf (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (res_push),
		.res           (res),
		.full          (buf_full),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive_valid   (drive_valid),
		.drive_command (drive_command),
		.manual_mode   (manual_mode)
	);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: drive mode controller self-checking bench
// Drives ticks, link bytes and control steps with random gaps and result
// stalls, predicts every result from a model of the mode, frame and avoidance
// state, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import rdmc_pkg::*;

	// no package name for the unused command code
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// cycles without any accepted item, taken result or write before the run is abandoned
	localparam int STALL_LIMIT = 1000;
	// length of the receiver hold-off that fills the block
	localparam int LONG_HOLD = 60;

	// ------------------------------------------------------------------------
	// Expected-drive scoreboard: holds its own copy of settings and state
	// ------------------------------------------------------------------------
	class drive_scoreboard;
		logic [9:0]            obstacle_cm;
		logic [14:0]           dead_zone;
		logic [9:0]            timeout_ms;
		logic [15:0]           reverse_ms, backup_ms, turn_ms, retry_ms, resume_ms;
		logic                  manual;
		logic [1:0]            avoid;
		logic [TIMER_BITS-1:0] hold_left;
		logic                  turn_right;
		logic [2:0]            frame_pos;
		logic [23:0]           frame_data;
		logic [9:0]            silence;
		res_t                  expected_drive_q[$];
		int                    errors;
		int                    checked;
		int                    drive_seen[9];

		function new();
			obstacle_cm = 10'd20;
			dead_zone   = 15'd100;
			timeout_ms  = 10'd50;
			reverse_ms  = 16'd800;
			backup_ms   = 16'd500;
			turn_ms     = 16'd1500;
			retry_ms    = 16'd300;
			resume_ms   = 16'd500;
			manual      = 1'b0;
			avoid       = AV_FWD;
			hold_left   = '0;
			turn_right  = 1'b0;
			frame_pos   = 3'd0;
			frame_data  = '0;
			silence     = '0;
			errors      = 0;
			checked     = 0;
			foreach (drive_seen[i]) drive_seen[i] = 0;
		endfunction

		function void set_register(logic [2:0] idx, logic [15:0] data);
			case (idx)
				REG_OBSTACLE: obstacle_cm = data[9:0];
				REG_DEADZONE: dead_zone   = data[14:0];
				REG_TIMEOUT:  timeout_ms  = data[9:0];
				REG_REVERSE:  reverse_ms  = data;
				REG_BACKUP:   backup_ms   = data;
				REG_TURN:     turn_ms     = data;
				REG_RETRY:    retry_ms    = data;
				REG_RESUME:   resume_ms   = data;
				default: ;
			endcase
		endfunction

		function logic [TIMER_BITS+40:0] state_word();
			return {manual, avoid, hold_left, turn_right, frame_pos, frame_data, silence};
		endfunction

		// load the hold timer, clipping to its largest value
		function void arm_hold(logic [15:0] ms);
			longint unsigned top;
			top = (64'd1 << TIMER_BITS) - 64'd1;
			hold_left = (64'(ms) > top) ? TIMER_BITS'(top) : TIMER_BITS'(ms);
		endfunction

		// map a joystick frame through the dead zone
		function logic [3:0] joystick_drive(logic [15:0] x_word, logic [15:0] y_word);
			int x, y, dz;
			x  = $signed(x_word);
			y  = $signed(y_word);
			dz = int'(dead_zone);
			if (y > dz) begin
				return (x > dz) ? DRV_CURVE_R : (x < -dz) ? DRV_CURVE_L : DRV_FWD;
			end
			if (y < -dz) begin
				return (x > dz) ? DRV_BCURVE_R : (x < -dz) ? DRV_BCURVE_L : DRV_BACK;
			end
			return (x > dz) ? DRV_TURN_R : (x < -dz) ? DRV_TURN_L : DRV_STOP;
		endfunction

		// advance the state for one accepted item; report whether it did anything
		function bit note_item(logic [1:0] cmd, logic [7:0] b, logic [9:0] d);
			res_t                  want;
			logic [TIMER_BITS+40:0] was;
			logic [9:0]            lim;
			bit                    obstacle;
			was  = state_word();
			want = '0;
			case (cmd)
				CMD_TICK: begin
					if (hold_left != 0) hold_left--;
					if (manual) begin
						lim = (timeout_ms != 0) ? timeout_ms : 10'd1;
						if (silence != 10'h3FF) silence++;
						// link silent too long: stop and drop any partial frame
						if (silence >= lim) begin
							want.drive_valid   = 1'b1;
							want.drive_command = DRV_STOP;
							silence            = '0;
							frame_pos          = 3'd0;
						end
					end
				end
				CMD_BYTE: begin
					if (!manual) begin
						if (b == BYTE_TOGGLE) begin
							manual    = 1'b1;
							frame_pos = 3'd0;
							silence   = '0;
						end
					end else begin
						silence = '0;
						if (frame_pos == 3'd0) begin
							if (b == BYTE_TOGGLE) begin
								manual             = 1'b0;
								avoid              = AV_FWD;
								want.drive_valid   = 1'b1;
								want.drive_command = DRV_STOP;
							end else if (b == BYTE_START) begin
								frame_pos = 3'd1;
							end
						end else if (frame_pos < 3'd4) begin
							frame_data = {frame_data[15:0], b};
							frame_pos++;
						end else begin
							want.drive_valid   = 1'b1;
							want.drive_command = joystick_drive(frame_data[23:8],
								{frame_data[7:0], b});
							frame_pos          = 3'd0;
						end
					end
				end
				CMD_STEP: begin
					if (!manual && hold_left == 0) begin
						obstacle         = (d != 0) && (d < obstacle_cm);
						want.drive_valid = 1'b1;
						case (avoid)
							AV_FWD: begin
								if (obstacle) begin
									want.drive_command = DRV_STOP;
									avoid              = AV_REVERSE;
									arm_hold(reverse_ms);
								end else begin
									want.drive_command = DRV_FWD;
								end
							end
							AV_REVERSE: begin
								want.drive_command = DRV_BACK;
								avoid              = AV_TURN;
								arm_hold(backup_ms);
							end
							AV_TURN: begin
								want.drive_command = turn_right ? DRV_CURVE_R : DRV_CURVE_L;
								avoid              = AV_PAUSE;
								arm_hold(turn_ms);
							end
							default: begin
								want.drive_command = DRV_STOP;
								if (obstacle) begin
									avoid = AV_REVERSE;
									arm_hold(retry_ms);
								end else begin
									turn_right = ~turn_right;
									avoid      = AV_FWD;
									arm_hold(resume_ms);
								end
							end
						endcase
					end
				end
				default: ;
			endcase
			want.manual_mode = manual;
			if (want.drive_valid) drive_seen[want.drive_command]++;
			expected_drive_q.push_back(want);
			return want.drive_valid || (state_word() != was);
		endfunction

		function void check_drive(res_t got);
			res_t want;
			if (expected_drive_q.size() == 0) begin
				$error("unexpected result: drive_valid %0d drive_command %0d manual_mode %0d",
					got.drive_valid, got.drive_command, got.manual_mode);
				errors++;
				return;
			end
			want = expected_drive_q.pop_front();
			checked++;
			if (got.drive_valid !== want.drive_valid) begin
				$error("drive_valid: expected %0d, got %0d", want.drive_valid, got.drive_valid);
				errors++;
			end
			if (got.drive_command !== want.drive_command) begin
				$error("drive_command: expected %0d, got %0d",
					want.drive_command, got.drive_command);
				errors++;
			end
			if (got.manual_mode !== want.manual_mode) begin
				$error("manual_mode: expected %0d, got %0d", want.manual_mode, got.manual_mode);
				errors++;
			end
		endfunction

		function int pending();
			return expected_drive_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals and block under test
	// ------------------------------------------------------------------------
	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic [1:0]  command     = CMD_TICK;
	logic [7:0]  link_byte   = 8'h00;
	logic [9:0]  distance_cm = 10'd0;
	logic        out_ready   = 1'b0;
	logic        cfg_valid   = 1'b0;
	logic [2:0]  cfg_index   = REG_OBSTACLE;
	logic [15:0] cfg_data    = 16'h0000;
	wire         in_ready, out_valid, cfg_ready;
	wire         drive_valid, manual_mode;
	wire  [3:0]  drive_command;

	drive_scoreboard sb;
	bit quiet        = 1'b0;
	bit sender_eager = 1'b0;
	bit hold_req     = 1'b0;
	int total_items     = 0;
	int effective_items = 0;
	int cfg_phases      = 0;

	robot_drive_mode_controller dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.link_byte     (link_byte),
		.distance_cm   (distance_cm),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive_valid   (drive_valid),
		.drive_command (drive_command),
		.manual_mode   (manual_mode),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 12 ns clock
	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Random choices
	// ------------------------------------------------------------------------
	// mostly back to back, sometimes short gaps, now and then a long one
	function int idle_gap();
		int r;
		if (quiet || sender_eager) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// favour readings on either side of the obstacle threshold
	function logic [9:0] range_reading();
		case ($urandom_range(0, 9))
			0:       return 10'd0;
			1:       return 10'(sb.obstacle_cm - 10'd1);
			2:       return sb.obstacle_cm;
			3, 4:    return 10'($urandom_range(0, sb.obstacle_cm));
			default: return 10'($urandom_range(1, 1023));
		endcase
	endfunction

	// favour joystick values at the dead zone edges and the word extremes
	function logic [15:0] joystick_word();
		int dz;
		dz = int'(sb.dead_zone);
		case ($urandom_range(0, 7))
			0:       return 16'($urandom);
			1:       return 16'(dz);
			2:       return 16'(dz + 1);
			3:       return 16'(-dz);
			4:       return 16'(-dz - 1);
			5:       return 16'h0000;
			6:       return 16'h7FFF;
			default: return 16'h8000;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------
	task automatic send_item(logic [1:0] cmd, logic [7:0] b, logic [9:0] d);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		link_byte   <= b;
		distance_cm <= d;
		do @(posedge clk); while (!in_ready);
		total_items++;
		if (sb.note_item(cmd, b, d)) effective_items++;
	endtask

	task automatic send_tick();
		send_item(CMD_TICK, 8'($urandom), 10'($urandom));
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(CMD_BYTE, b, 10'($urandom));
	endtask

	task automatic send_step(logic [9:0] d);
		send_item(CMD_STEP, 8'($urandom), d);
	endtask

	task automatic send_frame(logic [15:0] x_word, logic [15:0] y_word);
		send_byte(BYTE_START);
		send_byte(x_word[15:8]);
		send_byte(x_word[7:0]);
		send_byte(y_word[15:8]);
		send_byte(y_word[7:0]);
	endtask

	// tick without gaps until the avoidance hold has run out
	task automatic run_out_hold();
		quiet = 1'b1;
		while (sb.hold_left != 0) send_tick();
		quiet = 1'b0;
	endtask

	// drop valid and wait for every outstanding result
	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
	endtask

	task automatic configure(logic [9:0] obst, logic [14:0] dz, logic [9:0] tmo,
			logic [15:0] rev, logic [15:0] bck, logic [15:0] trn,
			logic [15:0] rty, logic [15:0] rsm);
		wait_drain();
		write_reg(REG_OBSTACLE, 16'(obst));
		write_reg(REG_DEADZONE, 16'(dz));
		write_reg(REG_TIMEOUT,  16'(tmo));
		write_reg(REG_REVERSE,  rev);
		write_reg(REG_BACKUP,   bck);
		write_reg(REG_TURN,     trn);
		write_reg(REG_RETRY,    rty);
		write_reg(REG_RESUME,   rsm);
		cfg_valid <= 1'b0;
		cfg_phases++;
	endtask

	// one burst of activity: frames, toggles, ticks, steps, broken frames, noise
	task automatic random_scene();
		int          pick, n;
		logic [15:0] x_word, y_word;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			x_word = joystick_word();
			y_word = joystick_word();
			send_frame(x_word, y_word);
		end else if (pick < 43) begin
			send_byte(BYTE_TOGGLE);
		end else if (pick < 60) begin
			n = $urandom_range(1, (sb.timeout_ms > 30) ? 32 : sb.timeout_ms + 2);
			repeat (n) send_tick();
		end else if (pick < 85) begin
			// usually let a short hold expire so the steps are taken
			if (sb.hold_left < 30 && $urandom_range(0, 9) < 7) begin
				repeat (sb.hold_left) send_tick();
			end
			n = $urandom_range(1, 6);
			repeat (n) send_step(range_reading());
		end else if (pick < 92) begin
			// frame cut short, data bytes may look like start or toggle
			send_byte(BYTE_START);
			n = $urandom_range(0, 3);
			repeat (n) begin
				case ($urandom_range(0, 3))
					0:       send_byte(BYTE_TOGGLE);
					1:       send_byte(BYTE_START);
					default: send_byte(8'($urandom));
				endcase
			end
		end else begin
			send_item(2'($urandom_range(0, 3)), 8'($urandom), 10'($urandom));
		end
	endtask

	// send random scenes until about the given number of items has gone in
	task automatic run_random(int target);
		int base;
		base = total_items;
		while (total_items - base < target) random_scene();
	endtask

	// ------------------------------------------------------------------------
	// Result side: check each result, stall at random, hold off on request
	// ------------------------------------------------------------------------
	initial begin : result_side
		res_t seen;
		int   stall_left;
		int   r;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				seen.drive_valid   = drive_valid;
				seen.drive_command = drive_command;
				seen.manual_mode   = manual_mode;
				sb.check_drive(seen);
			end
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = LONG_HOLD;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (quiet) begin
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					out_ready <= 1'b1;
				end else if (r < 95) begin
					stall_left = $urandom_range(0, 2);
					out_ready <= 1'b0;
				end else begin
					stall_left = $urandom_range(9, 39);
					out_ready <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: give up when nothing moves on any channel for too long
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items under reset settings
		send_step(10'd0);
		send_step(10'd1023);
		send_step(10'd20);
		send_step(10'd21);
		send_tick();
		send_item(CMD_UNUSED, 8'hFF, 10'd1023);
		send_byte(8'h00);
		send_byte(BYTE_START);
		send_byte(BYTE_TOGGLE);
		send_step(10'd5);
		send_byte(8'h12);
		send_frame(16'h7FFF, 16'h8000);
		send_frame(16'hFEFF, 16'hFFFE);
		send_tick();
		send_byte(BYTE_TOGGLE);
		send_step(10'd20);

		// widest settings: full dead zone and timeout, short holds run out in full
		configure(10'd1023, 15'd32767, 10'd1023, 16'd40, 16'd0, 16'd0, 16'd40, 16'hFFFF);
		run_out_hold();
		send_byte(BYTE_TOGGLE);
		send_frame(16'h8000, 16'h8000);
		send_frame(16'h7FFF, 16'h0000);
		send_frame(joystick_word(), joystick_word());
		repeat (3) send_tick();
		send_byte(BYTE_TOGGLE);
		send_step(10'd3);
		run_out_hold();
		send_step(10'd3);
		send_step(10'd3);
		send_step(10'd500);
		run_out_hold();

		// narrowest settings: readings 1 to 1022 are obstacles, no holds, instant timeout
		configure(10'd1023, 15'd0, 10'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_random(210);

		// moderate settings, with the output held off while items keep coming
		configure(10'($urandom_range(10, 300)), 15'($urandom_range(0, 3000)),
			10'($urandom_range(2, 12)), 16'($urandom_range(0, 10)),
			16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)),
			16'($urandom_range(0, 10)), 16'($urandom_range(0, 10)));
		run_random(130);
		sender_eager = 1'b1;
		hold_req     = 1'b1;
		repeat (8) send_tick();
		sender_eager = 1'b0;
		run_random(130);

		// broad random settings, with a full drain in the middle
		configure(10'($urandom_range(1, 1023)), 15'($urandom_range(0, 32767)),
			10'($urandom_range(1, 25)), 16'($urandom_range(0, 25)),
			16'($urandom_range(0, 25)), 16'($urandom_range(0, 25)),
			16'($urandom_range(0, 25)), 16'($urandom_range(0, 25)));
		run_random(130);
		wait_drain();
		run_random(130);

		// no obstacle can be seen; run without any idling
		configure(10'd1, 15'd100, 10'd50, 16'd2, 16'd2, 16'd2, 16'd2, 16'd2);
		quiet = 1'b1;
		run_random(210);
		quiet = 1'b0;

		wait_drain();
		repeat (10) @(posedge clk);

		$display("Sent %0d items (%0d changed state or drove), checked %0d results over %0d settings",
			total_items, effective_items, sb.checked, cfg_phases);
		$display("Drives stop %0d fwd %0d back %0d curve %0d/%0d back-curve %0d/%0d turn %0d/%0d",
			sb.drive_seen[0], sb.drive_seen[1], sb.drive_seen[2], sb.drive_seen[3],
			sb.drive_seen[4], sb.drive_seen[5], sb.drive_seen[6], sb.drive_seen[7],
			sb.drive_seen[8]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/rdmc_pkg.sv
sv/rdmc_cfg.sv
sv/rdmc_core.sv
sv/rdmc_outbuf.sv
sv/robot_drive_mode_controller.sv
tb/testbench.sv
